@@ src/tagal_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, codes and helper functions for the tag ID allow-list table.
// Used by tag_id_allow_list_table_top; no dependencies of its own.
package tagal_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 32;
  localparam int KEY_BITS    = 40;
  localparam int IDX_BITS    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Port field widths.
  localparam int OP_W     = 2;
  localparam int TAG_W    = 40;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 5;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ZERO_TAG  = 3'd4;

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [IDX_BITS-1:0] idx_t;

  // Low KEY_BITS bits of the tag, zero extended when the key is wider.
  function automatic key_t tag_to_key(input logic [TAG_W-1:0] tag);
    logic [KEY_BITS+TAG_W-1:0] wide;
    wide = (KEY_BITS + TAG_W)'(tag);
    return wide[KEY_BITS-1:0];
  endfunction

  // Low SLOT_W bits of a slot index, zero extended for shallow tables.
  function automatic logic [SLOT_W-1:0] idx_to_slot(input idx_t idx);
    logic [SLOT_W+IDX_BITS-1:0] wide;
    wide = (SLOT_W + IDX_BITS)'(idx);
    return wide[SLOT_W-1:0];
  endfunction

endpackage

@@ src/tagal_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tagal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                            clk,
  input  logic                                            we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    waddr,
  input  logic [WIDTH-1:0]                                wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    raddr,
  output logic [WIDTH-1:0]                                rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/tag_id_allow_list_table_top.sv @@
`timescale 1ns / 1ps
// Top level of the tag ID allow-list table: sequencer, slot valid bits and output register.
// Depends on tagal_pkg and tagal_ram.

// The block keeps a table of tag identifiers and answers one request per input
// transfer with exactly one result transfer. A request carries an operation in
// s_tuser (lookup, insert, delete, clear) and a tag in s_tdata. A request whose
// tag is all zero is refused with the zero-tag status and changes nothing; a
// clear empties every slot at once without a scan. Lookup, insert and delete
// scan the table one slot at a time through the single read port of the key
// RAM, each slot in an address state and then a compare state (S_RD, S_CMP),
// over up to all 32 slots; a lookup, delete or duplicate insert stops at the
// lowest matching slot and is faster. The same compare pass records the
// lowest empty slot, so an insert needs only one pass. s_tready is low while
// a request is being worked on. The result sits in an output register, so
// the next request is accepted while the previous result still waits for
// m_tready. Slot occupancy is kept in one flip-flop per slot that reset
// clears, so no clearing pass is needed after reset.
module tag_id_allow_list_table_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [39:0] tag_id
  input  logic [1:0]  s_tuser,   // [1:0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [2:0] status, [3] hit, [8:4] slot, [15:9] zero
);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam tagal_pkg::idx_t LAST_IDX = tagal_pkg::IDX_BITS'(tagal_pkg::TABLE_DEPTH - 1);

  logic [1:0]                          state;
  logic [tagal_pkg::OP_W-1:0]          op;
  tagal_pkg::key_t                     key;
  logic                                zero_tag;
  tagal_pkg::idx_t                     idx;
  logic                                found;
  tagal_pkg::idx_t                     match_idx;
  logic                                free_found;
  tagal_pkg::idx_t                     free_idx;
  logic [tagal_pkg::TABLE_DEPTH-1:0]   valid;

  // RAM ports.
  logic                                ram_we;
  tagal_pkg::key_t                     ram_rdata;

  // Current compare, valid in S_CMP.
  logic                                slot_match;
  logic                                slot_empty;

  // Result of the finished request.
  logic [tagal_pkg::STATUS_W-1:0]      res_status;
  logic                                res_hit;
  tagal_pkg::idx_t                     res_idx;
  logic                                out_free;
  tagal_pkg::key_t                     in_key;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign in_key   = tagal_pkg::tag_to_key(s_tdata);

  assign slot_match = valid[idx] && (ram_rdata == key);
  assign slot_empty = !valid[idx];

  // An insert writes the key into the lowest empty slot when the tag is new.
  assign ram_we = (state == S_DONE) && out_free && !zero_tag && (op == tagal_pkg::OP_INSERT) &&
                  !found && free_found;

  tagal_ram #(
    .WIDTH (tagal_pkg::KEY_BITS),
    .DEPTH (tagal_pkg::TABLE_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx),
    .wdata (key),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  // Result decode from the operation and what the scan found.
  always_comb begin
    res_status = tagal_pkg::ST_OK;
    res_hit    = 1'b0;
    res_idx    = '0;
    if (zero_tag) begin
      res_status = tagal_pkg::ST_ZERO_TAG;
    end else begin
      unique case (op)
        tagal_pkg::OP_LOOKUP, tagal_pkg::OP_DELETE: begin
          if (found) begin
            res_hit = 1'b1;
            res_idx = match_idx;
          end else begin
            res_status = tagal_pkg::ST_NOT_FOUND;
          end
        end
        tagal_pkg::OP_INSERT: begin
          if (found) begin
            res_status = tagal_pkg::ST_PRESENT;
            res_hit    = 1'b1;
            res_idx    = match_idx;
          end else if (free_found) begin
            res_idx = free_idx;
          end else begin
            res_status = tagal_pkg::ST_FULL;
          end
        end
        default: begin
          // Clear reports ok with no hit and slot zero.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      valid      <= '0;
      m_tvalid   <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
      idx        <= '0;
    end else begin
      // A new result takes the output register as the old one leaves it.
      if ((state == S_DONE) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op         <= s_tuser;
            key        <= in_key;
            zero_tag   <= (in_key == '0);
            idx        <= '0;
            found      <= 1'b0;
            free_found <= 1'b0;
            match_idx  <= '0;
            free_idx   <= '0;
            if ((in_key == '0) || (s_tuser == tagal_pkg::OP_CLEAR)) begin
              state <= S_DONE;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (slot_empty && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= idx;
          end
          if (slot_match) begin
            found     <= 1'b1;
            match_idx <= idx;
            state     <= S_DONE;
          end else if (idx == LAST_IDX) begin
            state <= S_DONE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_RD;
          end
        end
        S_DONE: begin
          if (out_free) begin
            if (!zero_tag) begin
              if (op == tagal_pkg::OP_CLEAR) begin
                valid <= '0;
              end else if ((op == tagal_pkg::OP_DELETE) && found) begin
                valid[match_idx] <= 1'b0;
              end else if ((op == tagal_pkg::OP_INSERT) && !found && free_found) begin
                valid[free_idx] <= 1'b1;
              end
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output payload register; loaded together with m_tvalid.
  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      m_tdata <= {7'd0, tagal_pkg::idx_to_slot(res_idx), res_hit, res_status};
    end
  end

endmodule
